### rtl/ordered_array_list_engine_core_assert.svh
// Assertion macros shared by the ordered list engine RTL.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// Condition must hold whenever the antecedent holds, same edge
`define OAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Condition must hold on the edge after the antecedent
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/oal_pkg.sv
// Package for the ordered list engine: sizes, codes, microword layout
// and the microcode ROM. No dependencies.
package oal_pkg;

    // Sizes
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int CMP_W  = PTR_W + POS_W;
    localparam int DATA_W = 32;
    localparam int STEP_W = 5;

    typedef logic [STEP_W-1:0] t_step;

    // Request and status codes
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_UPDATE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_FULL,
        C_BAD_INS,
        C_BAD_DEL,
        C_PTR_LT_POS,
        C_DEL_END,
        C_PTR_GE_CNT,
        C_MATCH,
        C_NOT_UPDATE
    } t_cond;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_CNT,
        PTR_POSM1,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTRM1,
        RD_PTRP1,
        RD_POSM1
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_RD_AT_PTR,
        WR_VAL_AT_POS,
        WR_REP_AT_PTR
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // One control word
    typedef struct packed {
        t_cond   cond;
        t_step   target;
        t_ptr_op ptr_op;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_cnt_op cnt_op;
        logic    set_status;
        t_status status;
        logic    set_found;
        logic    set_removed;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   accept;
        logic   emit;
        logic   run;
        t_uword uw;
    } t_dp_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic full;
        logic bad_ins;
        logic bad_del;
        logic ptr_lt_pos;
        logic del_end;
        logic ptr_ge_cnt;
        logic match;
        logic not_update;
    } t_dp_flags;

    // Program addresses
    localparam t_step STEP_IDLE  = 5'd0;
    localparam t_step STEP_I0    = 5'd1;
    localparam t_step STEP_I1    = 5'd2;
    localparam t_step STEP_I2    = 5'd3;
    localparam t_step STEP_I3    = 5'd4;
    localparam t_step STEP_I4    = 5'd5;
    localparam t_step STEP_D0    = 5'd6;
    localparam t_step STEP_D1    = 5'd7;
    localparam t_step STEP_D2    = 5'd8;
    localparam t_step STEP_D3    = 5'd9;
    localparam t_step STEP_D4    = 5'd10;
    localparam t_step STEP_S0    = 5'd11;
    localparam t_step STEP_S1    = 5'd12;
    localparam t_step STEP_S2    = 5'd13;
    localparam t_step STEP_S3    = 5'd14;
    localparam t_step STEP_S4    = 5'd15;
    localparam t_step STEP_S5    = 5'd16;
    localparam t_step STEP_FFULL = 5'd17;
    localparam t_step STEP_FBAD  = 5'd18;
    localparam t_step STEP_FNF   = 5'd19;
    localparam t_step STEP_DONE  = 5'd20;
    localparam t_step STEP_LAST  = STEP_DONE;

    localparam t_uword UW_NOP = '{
        cond: C_NEXT, target: STEP_IDLE, ptr_op: PTR_HOLD, rd_sel: RD_PTR,
        wr_sel: WR_NONE, cnt_op: CNT_HOLD, set_status: 1'b0, status: ST_OK,
        set_found: 1'b0, set_removed: 1'b0
    };

    // Microcode ROM
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = UW_NOP;
        case (s)
            // insert: check, then walk down from count moving entries up
            STEP_I0: begin
                w.cond = C_FULL;    w.target = STEP_FFULL; w.ptr_op = PTR_CNT;
            end
            STEP_I1: begin
                w.cond = C_BAD_INS; w.target = STEP_FBAD;
            end
            STEP_I2: begin
                w.cond = C_PTR_LT_POS; w.target = STEP_I4; w.rd_sel = RD_PTRM1;
            end
            STEP_I3: begin
                w.cond = C_ALWAYS; w.target = STEP_I2;
                w.wr_sel = WR_RD_AT_PTR; w.ptr_op = PTR_DEC;
            end
            STEP_I4: begin
                w.cond = C_ALWAYS; w.target = STEP_DONE;
                w.wr_sel = WR_VAL_AT_POS; w.cnt_op = CNT_INC;
            end
            // delete: fetch the victim, then walk up moving entries down
            STEP_D0: begin
                w.cond = C_BAD_DEL; w.target = STEP_FBAD;
                w.ptr_op = PTR_POSM1; w.rd_sel = RD_POSM1;
            end
            STEP_D1: begin
                w.set_removed = 1'b1;
            end
            STEP_D2: begin
                w.cond = C_DEL_END; w.target = STEP_D4; w.rd_sel = RD_PTRP1;
            end
            STEP_D3: begin
                w.cond = C_ALWAYS; w.target = STEP_D2;
                w.wr_sel = WR_RD_AT_PTR; w.ptr_op = PTR_INC;
            end
            STEP_D4: begin
                w.cond = C_ALWAYS; w.target = STEP_DONE; w.cnt_op = CNT_DEC;
            end
            // search and update: linear scan for the first match
            STEP_S0: begin
                w.ptr_op = PTR_ZERO;
            end
            STEP_S1: begin
                w.cond = C_PTR_GE_CNT; w.target = STEP_FNF; w.rd_sel = RD_PTR;
            end
            STEP_S2: begin
                w.cond = C_MATCH; w.target = STEP_S4;
            end
            STEP_S3: begin
                w.cond = C_ALWAYS; w.target = STEP_S1; w.ptr_op = PTR_INC;
            end
            STEP_S4: begin
                w.cond = C_NOT_UPDATE; w.target = STEP_DONE; w.set_found = 1'b1;
            end
            STEP_S5: begin
                w.cond = C_ALWAYS; w.target = STEP_DONE; w.wr_sel = WR_REP_AT_PTR;
            end
            // error exits
            STEP_FFULL: begin
                w.cond = C_ALWAYS; w.target = STEP_DONE;
                w.set_status = 1'b1; w.status = ST_FULL;
            end
            STEP_FBAD: begin
                w.cond = C_ALWAYS; w.target = STEP_DONE;
                w.set_status = 1'b1; w.status = ST_BADPOS;
            end
            STEP_FNF: begin
                w.cond = C_ALWAYS; w.target = STEP_DONE;
                w.set_status = 1'b1; w.status = ST_NOTFOUND;
            end
            STEP_DONE: begin
                w.cond = C_ALWAYS; w.target = STEP_IDLE;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // Widening helpers for compares
    function automatic logic [CMP_W-1:0] ext_ptr(input logic [PTR_W-1:0] x);
        return {{POS_W{1'b0}}, x};
    endfunction

    function automatic logic [CMP_W-1:0] ext_pos(input logic [POS_W-1:0] p);
        return {{PTR_W{1'b0}}, p};
    endfunction

    // Result fields are five bits wide whatever the depth
    function automatic logic [POS_W-1:0] out_bits(input logic [PTR_W-1:0] x);
        logic [CMP_W-1:0] t;
        t = ext_ptr(x);
        return t[POS_W-1:0];
    endfunction

endpackage

### rtl/oal_ctrl.sv
// Microcode sequencer for the ordered list engine: step counter, ROM
// lookup, jump selection and the beat handshakes. Depends on oal_pkg.
`include "ordered_array_list_engine_core_assert.svh"

module oal_ctrl import oal_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic [1:0] i_req_type,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_dp_flags i_flags,
    output t_dp_ctl   o_ctl
);

    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;
    t_uword uw;
    logic   accept, stall, emit, jump;

    // Control word for the current step
    assign uw = ucode(r_step);

    // Handshake: new beat only in idle, result waits for a free output slot
    assign o_in_ready = (r_step == STEP_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign stall      = (r_step == STEP_DONE) && r_out_valid && !i_out_ready;
    assign emit       = (r_step == STEP_DONE) && !stall;

    // Jump condition select
    always_comb begin
        case (uw.cond)
            C_NEXT:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_FULL:       jump = i_flags.full;
            C_BAD_INS:    jump = i_flags.bad_ins;
            C_BAD_DEL:    jump = i_flags.bad_del;
            C_PTR_LT_POS: jump = i_flags.ptr_lt_pos;
            C_DEL_END:    jump = i_flags.del_end;
            C_PTR_GE_CNT: jump = i_flags.ptr_ge_cnt;
            C_MATCH:      jump = i_flags.match;
            C_NOT_UPDATE: jump = i_flags.not_update;
            default:      jump = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        n_step = r_step;
        if (r_step == STEP_IDLE) begin
            if (accept) begin
                case (t_req'(i_req_type))
                    REQ_INSERT: n_step = STEP_I0;
                    REQ_DELETE: n_step = STEP_D0;
                    REQ_SEARCH: n_step = STEP_S0;
                    REQ_UPDATE: n_step = STEP_S0;
                    default:    n_step = STEP_IDLE;
                endcase
            end
        end else if (stall) begin
            n_step = r_step;
        end else if (jump) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // Output slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath control
    always_comb begin
        o_ctl.accept = accept;
        o_ctl.emit   = emit;
        o_ctl.run    = (r_step != STEP_IDLE) && !stall;
        o_ctl.uw     = uw;
    end

    assign o_out_valid = r_out_valid;

    // Checks
    `OAL_ASSERT_NOW(a_step_in_program, 1'b1, r_step <= STEP_LAST, "step beyond program")
    `OAL_ASSERT_NEXT(a_accept_leaves_idle, accept, r_step != STEP_IDLE, "request not dispatched")
    `OAL_ASSERT_NEXT(a_emit_fills_slot, emit, r_out_valid && r_step == STEP_IDLE,
        "result not presented")

endmodule

### rtl/oal_dpath.sv
// Datapath of the ordered list engine: request registers, walk pointer,
// entry count, entry memory and result registers. Depends on oal_pkg.
module oal_dpath import oal_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctl            i_ctl,
    input  logic [1:0]         i_req_type,
    input  logic [POS_W-1:0]   i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic signed [DATA_W-1:0] i_replacement,
    output t_dp_flags          o_flags,
    output logic [1:0]         o_status,
    output logic [POS_W-1:0]   o_found_position,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [POS_W-1:0]   o_entry_count
);

    // Entry store
    logic [DATA_W-1:0] mem [DEPTH];

    logic [1:0]        r_op;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val, r_rep, r_rd;
    logic [PTR_W-1:0]  r_ptr, n_ptr, r_cnt, n_cnt;
    t_status           r_status;
    logic [PTR_W-1:0]  r_found;
    logic [DATA_W-1:0] r_removed;
    logic [1:0]        r_o_status;
    logic [POS_W-1:0]  r_o_found, r_o_count;
    logic [DATA_W-1:0] r_o_removed;

    logic [CMP_W-1:0]  posm1_w;
    logic [PTR_W-1:0]  posm1, rd_full, wr_full;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    t_uword            uw;

    assign uw      = i_ctl.uw;
    assign posm1_w = ext_pos(r_pos) - CMP_W'(1);
    assign posm1   = posm1_w[PTR_W-1:0];

    // Flags for the sequencer
    always_comb begin
        o_flags.full       = ext_ptr(r_cnt) >= CMP_W'(DEPTH);
        o_flags.bad_ins    = (r_pos == '0) || (ext_pos(r_pos) > ext_ptr(r_cnt) + CMP_W'(1));
        o_flags.bad_del    = (r_pos == '0) || (ext_pos(r_pos) > ext_ptr(r_cnt));
        o_flags.ptr_lt_pos = ext_ptr(r_ptr) < ext_pos(r_pos);
        o_flags.del_end    = ext_ptr(r_ptr) + CMP_W'(1) >= ext_ptr(r_cnt);
        o_flags.ptr_ge_cnt = r_ptr >= r_cnt;
        o_flags.match      = r_rd == r_val;
        o_flags.not_update = t_req'(r_op) != REQ_UPDATE;
    end

    // Memory addressing
    always_comb begin
        case (uw.rd_sel)
            RD_PTR:   rd_full = r_ptr;
            RD_PTRM1: rd_full = r_ptr - 1'b1;
            RD_PTRP1: rd_full = r_ptr + 1'b1;
            RD_POSM1: rd_full = posm1;
            default:  rd_full = r_ptr;
        endcase
        rd_addr = rd_full[IDX_W-1:0];

        wr_en   = i_ctl.run;
        wr_full = r_ptr;
        wr_data = r_rd;
        case (uw.wr_sel)
            WR_NONE:       wr_en = 1'b0;
            WR_RD_AT_PTR:  wr_data = r_rd;
            WR_VAL_AT_POS: begin
                wr_full = posm1;
                wr_data = r_val;
            end
            WR_REP_AT_PTR: wr_data = r_rep;
            default:       wr_en = 1'b0;
        endcase
        wr_addr = wr_full[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    // Walk pointer and count
    always_comb begin
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        if (i_ctl.run) begin
            case (uw.ptr_op)
                PTR_HOLD:  n_ptr = r_ptr;
                PTR_CNT:   n_ptr = r_cnt;
                PTR_POSM1: n_ptr = posm1;
                PTR_ZERO:  n_ptr = '0;
                PTR_INC:   n_ptr = r_ptr + 1'b1;
                PTR_DEC:   n_ptr = r_ptr - 1'b1;
                default:   n_ptr = r_ptr;
            endcase
            case (uw.cnt_op)
                CNT_HOLD: n_cnt = r_cnt;
                CNT_INC:  n_cnt = r_cnt + 1'b1;
                CNT_DEC:  n_cnt = r_cnt - 1'b1;
                default:  n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Request latch and result build-up
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_ctl.accept) begin
            r_op      <= i_req_type;
            r_pos     <= i_position;
            r_val     <= i_item_value;
            r_rep     <= i_replacement;
            r_status  <= ST_OK;
            r_found   <= '0;
            r_removed <= '0;
        end else if (i_ctl.run) begin
            if (uw.set_status) begin
                r_status <= uw.status;
            end
            if (uw.set_found) begin
                r_found <= r_ptr + 1'b1;
            end
            if (uw.set_removed) begin
                r_removed <= r_rd;
            end
        end
    end

    // Output register, loaded as the result beat is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_o_status  <= r_status;
            r_o_found   <= out_bits(r_found);
            r_o_removed <= r_removed;
            r_o_count   <= out_bits(r_cnt);
        end
    end

    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_removed_value  = r_o_removed;
    assign o_entry_count    = r_o_count;

endmodule

### rtl/ordered_array_list_engine_core.sv
// Ordered list engine: one request beat in, one result beat out. Each
// request runs a short microprogram that steps a simple dual-port entry
// memory (one write and one registered read per cycle). Each moved entry
// is read and then written, and each compared entry is read, compared and
// then stepped past, so timing depends on the list: full list or bad
// position requests go straight to an error exit, an insert walks down
// from the end to the position, a delete walks up from the position to
// the end, and a search scans from the front to the first match or the
// end. A new request is taken once the previous one has put its result
// into the output register. Depends on oal_pkg, oal_ctrl, oal_dpath.
module ordered_array_list_engine_core import oal_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [POS_W-1:0]   i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic signed [DATA_W-1:0] i_replacement,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [POS_W-1:0]   o_found_position,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [POS_W-1:0]   o_entry_count
);

    t_dp_ctl   ctl;
    t_dp_flags flags;

    // Sequencer
    oal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_flags     (flags),
        .o_ctl       (ctl)
    );

    // Datapath
    oal_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .i_replacement    (i_replacement),
        .o_flags          (flags),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_removed_value  (o_removed_value),
        .o_entry_count    (o_entry_count)
    );

endmodule
